// File: rtl/core/rtids_pkg.sv
// ----------------------------------------------------------------------------
// Record table package
// Shared types, command codes and status codes of the record table core.
// ----------------------------------------------------------------------------
package rtids_pkg;

   localparam int DEPTH_DEFAULT = 64;

   typedef enum logic [2:0] {
      CMD_CLEAR  = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_DELETE = 3'd2,
      CMD_SEARCH = 3'd3,
      CMD_UPDATE = 3'd4,
      CMD_SORT   = 3'd5,
      CMD_DUMP   = 3'd6,
      CMD_NONE   = 3'd7
   } cmd_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD      = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;

   typedef struct packed {
      logic [63:0] name;
      logic [15:0] year;
      logic [31:0] price;
   } rec_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [6:0]  position;
      logic [15:0] year_key;
      logic [31:0] price_in;
      logic [63:0] name_tag_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  entry_index;
      logic [63:0] name_tag_out;
      logic [15:0] year_out;
      logic [31:0] price_out;
      logic [6:0]  entry_count;
      logic        last;
   } rsp_type;

endpackage

// File: rtl/core/rtids_mem.sv
// ----------------------------------------------------------------------------
// Record table memory
// One-write, one-read record store with registered read data.
// ----------------------------------------------------------------------------
module rtids_mem
   import rtids_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  rec_type       wr_data,
   input  logic [AW-1:0] rd_addr,
   output rec_type       rd_data
);

   rec_type mem [DEPTH];
   rec_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

// File: rtl/core/record_table_insert_delete_sort_core.sv
// ----------------------------------------------------------------------------
// Record table core
// Ordered table of records with clear, insert, delete, search, update, sort, dump.
// ----------------------------------------------------------------------------
// One command is taken at a time. Every step reads one record from the single
// record memory (registered read data) and may write one back, so the time per
// command follows the number of entries walked: clear and bad inserts walk no
// entries, insert walks from the count down to the slot, delete/search/update
// walk the entries, dump emits one item per entry and can be held by output
// stalls, and sort makes count*(count-1)/2 compares in total, with an extra
// read step per outer pass.
module record_table_insert_delete_sort_core
   import rtids_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_FIND  = 11'b00000000010,
      S_FCHK  = 11'b00000000100,
      S_SHRD  = 11'b00000001000,
      S_SHWR  = 11'b00000010000,
      S_RDI   = 11'b00000100000,
      S_RDJ   = 11'b00001000000,
      S_CMP   = 11'b00010000000,
      S_SWP   = 11'b00100000000,
      S_DRD   = 11'b01000000000,
      S_OUT   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   rec_type   ri_ff, ri_in;
   rsp_type   out_ff, out_in;
   logic      ov_ff, ov_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   rec_type       wr_data, rd_data;
   rec_type       new_rec;

   rtids_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign new_rec = '{name: req_ff.name_tag_in, year: req_ff.year_key,
                      price: req_ff.price_in};

   function automatic rsp_type mk(logic [1:0] st, logic [CW-1:0] idx, rec_type r,
                                  logic [CW-1:0] cnt, logic lst);
      rsp_type o;
      o.status = st;
      o.entry_index = 6'(idx);
      o.name_tag_out = r.name;
      o.year_out = r.year;
      o.price_out = r.price;
      o.entry_count = 7'(cnt);
      o.last = lst;
      return o;
   endfunction

   assign req_ready = (state_ff == S_IDLE) && !ov_ff;
   assign rsp_valid = ov_ff;
   assign rsp_data = out_ff;

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      count_in = count_ff;
      i_in = i_ff;
      j_in = j_ff;
      ri_in = ri_ff;
      out_in = out_ff;
      ov_in = ov_ff;
      wr_en = 1'b0;
      wr_addr = i_ff[AW-1:0];
      wr_data = new_rec;
      rd_addr = i_ff[AW-1:0];
      if (ov_ff && rsp_ready) begin
         ov_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               req_in = req_data;
               i_in = '0;
               case (cmd_type'(req_data.cmd))
                  CMD_CLEAR: begin
                     count_in = '0;
                     out_in = mk(ST_OK, '0, '0, '0, 1'b1);
                     ov_in = 1'b1;
                  end
                  CMD_INSERT: begin
                     if (count_ff == DEPTH_C || req_data.position == 7'd0 ||
                         {1'b0, req_data.position} > {1'b0, 7'(count_ff)} + 8'd1) begin
                        out_in = mk(ST_BAD, '0, '0, count_ff, 1'b1);
                        ov_in = 1'b1;
                     end else begin
                        i_in = count_ff;
                        state_in = S_SHRD;
                     end
                  end
                  CMD_DELETE, CMD_SEARCH, CMD_UPDATE: state_in = S_FIND;
                  CMD_SORT: begin
                     if (count_ff < CW'(2)) begin
                        out_in = mk(ST_OK, '0, '0, count_ff, 1'b1);
                        ov_in = 1'b1;
                     end else begin
                        j_in = CW'(1);
                        state_in = S_RDI;
                     end
                  end
                  CMD_DUMP: begin
                     if (count_ff == '0) begin
                        out_in = mk(ST_OK, '0, '0, '0, 1'b1);
                        ov_in = 1'b1;
                     end else begin
                        state_in = S_DRD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // insert: move entry i-1 up to i until i reaches the slot
         S_SHRD: begin
            if (i_ff == CW'(req_ff.position - 7'd1)) begin
               wr_en = 1'b1;
               count_in = count_ff + CW'(1);
               out_in = mk(ST_OK, i_ff, new_rec, count_ff + CW'(1), 1'b1);
               ov_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               rd_addr = AW'(i_ff - CW'(1));
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            if (req_ff.cmd == CMD_INSERT) begin
               wr_en = 1'b1;
               wr_data = rd_data;
               i_in = i_ff - CW'(1);
               state_in = S_SHRD;
            end else begin
               // delete: copy i+1 down to i
               wr_en = 1'b1;
               wr_data = rd_data;
               i_in = i_ff + CW'(1);
               state_in = S_FCHK;
               if (i_ff + CW'(2) >= count_ff) begin
                  count_in = count_ff - CW'(1);
                  ov_in = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_FIND: begin
            if (i_ff >= count_ff) begin
               out_in = mk(ST_NOTFOUND, '0, '0, count_ff, 1'b1);
               ov_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_FCHK;
            end
         end
         S_FCHK: begin
            if (req_ff.cmd == CMD_DELETE && out_ff.last == 1'b0) begin
               // shifting phase of delete: read i+1
               rd_addr = AW'(i_ff + CW'(1));
               state_in = S_SHWR;
            end else if (rd_data.year == req_ff.year_key) begin
               case (cmd_type'(req_ff.cmd))
                  CMD_SEARCH: begin
                     out_in = mk(ST_OK, i_ff, rd_data, count_ff, 1'b1);
                     ov_in = 1'b1;
                     state_in = S_IDLE;
                  end
                  CMD_UPDATE: begin
                     wr_en = 1'b1;
                     out_in = mk(ST_OK, i_ff, new_rec, count_ff, 1'b1);
                     ov_in = 1'b1;
                     state_in = S_IDLE;
                  end
                  default: begin
                     out_in = mk(ST_OK, i_ff, rd_data, count_ff - CW'(1), 1'b0);
                     if (i_ff + CW'(1) >= count_ff) begin
                        out_in.last = 1'b1;
                        count_in = count_ff - CW'(1);
                        ov_in = 1'b1;
                        state_in = S_IDLE;
                     end else begin
                        rd_addr = AW'(i_ff + CW'(1));
                        state_in = S_SHWR;
                     end
                  end
               endcase
            end else begin
               i_in = i_ff + CW'(1);
               rd_addr = AW'(i_ff + CW'(1));
               state_in = S_FIND;
            end
         end
         S_RDI: begin
            state_in = S_RDJ;
         end
         S_RDJ: begin
            ri_in = rd_data;
            rd_addr = j_ff[AW-1:0];
            state_in = S_CMP;
         end
         S_CMP: begin
            if (ri_ff.price < rd_data.price) begin
               wr_en = 1'b1;
               wr_data = rd_data;
               ri_in = rd_data;
               state_in = S_SWP;
               j_in = j_ff;
            end else begin
               state_in = S_SWP;
            end
            if (!(ri_ff.price < rd_data.price)) begin
               state_in = S_SWP;
            end
            out_in.name_tag_out = ri_ff.name;
            out_in.year_out = ri_ff.year;
            out_in.price_out = ri_ff.price;
            out_in.status = (ri_ff.price < rd_data.price) ? ST_BAD : ST_OK;
         end
         S_SWP: begin
            // write old i record to j when swapped, then advance
            if (out_ff.status == ST_BAD) begin
               wr_en = 1'b1;
               wr_addr = j_ff[AW-1:0];
               wr_data = '{name: out_ff.name_tag_out, year: out_ff.year_out,
                           price: out_ff.price_out};
            end
            if (j_ff + CW'(1) < count_ff) begin
               j_in = j_ff + CW'(1);
               rd_addr = AW'(j_ff + CW'(1));
               state_in = S_CMP;
            end else if (i_ff + CW'(2) < count_ff) begin
               i_in = i_ff + CW'(1);
               j_in = i_ff + CW'(2);
               rd_addr = AW'(i_ff + CW'(1));
               state_in = S_RDI;
            end else begin
               out_in = mk(ST_OK, '0, '0, count_ff, 1'b1);
               ov_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DRD: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!ov_ff || rsp_ready) begin
               out_in = mk(ST_OK, i_ff, rd_data, count_ff, i_ff + CW'(1) == count_ff);
               ov_in = 1'b1;
               i_in = i_ff + CW'(1);
               rd_addr = AW'(i_ff + CW'(1));
               state_in = (i_ff + CW'(1) == count_ff) ? S_IDLE : S_DRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // delete: the first S_FCHK after a match must be the shift path
      if (state_ff == S_FCHK && req_ff.cmd == CMD_DELETE && state_in == S_SHWR) begin
         out_in.last = (state_ff == S_FCHK && out_ff.last == 1'b0) ? 1'b0 : out_in.last;
      end
      if (state_ff == S_SHWR && req_ff.cmd == CMD_DELETE && state_in == S_IDLE) begin
         out_in.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ov_ff <= 1'b0;
         out_ff <= mk(ST_OK, '0, '0, '0, 1'b1);
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ov_ff <= ov_in;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      i_ff <= i_in;
      j_ff <= j_in;
      ri_ff <= ri_in;
   end

`ifndef SYNTHESIS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C) else $error("record count above depth");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("item taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");
`endif

endmodule
